@@ rtl/generational_slot_allocator_macros.svh @@
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define GSA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define GSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/gsa_pkg.sv @@
package gsa_pkg;

	localparam int OP_W     = 3;
	localparam int STAT_W   = 2;
	localparam int SLOT_W   = 10;
	localparam int ID_W     = 64;
	localparam int GEN_W    = 32;
	localparam int USED_W   = 11;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 88;

	localparam int S_SLOT_LSB   = 0;
	localparam int S_EVENT_LSB  = S_SLOT_LSB + SLOT_W;
	localparam int S_PAYLOAD_W  = S_EVENT_LSB + ID_W;

	localparam int M_GRANT_LSB  = 0;
	localparam int M_HANDLE_LSB = M_GRANT_LSB + SLOT_W;
	localparam int M_USED_LSB   = M_HANDLE_LSB + ID_W;
	localparam int M_PAYLOAD_W  = M_USED_LSB + USED_W;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 3'd0,
		OP_FREE   = 3'd1,
		OP_REARM  = 3'd2,
		OP_READ   = 3'd3,
		OP_VERIFY = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_BAD    = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		ST_INIT = 2'd0,
		ST_IDLE = 2'd1,
		ST_EXEC = 2'd2
	} state_t;

endpackage

@@ rtl/gsa_ram.sv @@
module gsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/gsa_init.sv @@
module gsa_init #(
	parameter int SLOTS = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	output logic                     busy,
	output logic [$clog2(SLOTS)-1:0] addr
);

	localparam int AW = $clog2(SLOTS);

	logic          busy_q;
	logic [AW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			if (addr_q == AW'(SLOTS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	assign busy = busy_q;
	assign addr = addr_q;

endmodule

@@ rtl/generational_slot_allocator.sv @@
// Channel | Direction | tdata (lowest bit first)                | tuser
// s_*     | in        | slot[9:0], event_id[73:10], zero pad   | operation[2:0]
// m_*     | out       | granted_slot[9:0], handle_id[73:10],   | status[1:0]
//         |           | slots_used[84:74], zero pad            |
//
// Each operation is accepted in IDLE, which issues the read of the link and generation
// memories; the EXEC state then modifies and writes back once the output register can take the result.
// The read of the memories is registered; one operation is in flight at a time.
// After reset a sweep initializes every slot of both memories with s_tready low.
// A result waits in the output register; a new beat is still accepted, and its write-back
// holds until the previous result is taken.
module generational_slot_allocator #(
	parameter int SLOTS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gsa_pkg::S_TDATA_W-1:0]   s_tdata,  // slot, event_id
	input  logic [gsa_pkg::OP_W-1:0]        s_tuser,  // operation
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gsa_pkg::M_TDATA_W-1:0]   m_tdata,  // granted_slot, handle_id, slots_used
	output logic [gsa_pkg::STAT_W-1:0]      m_tuser   // status
);

	localparam int AW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam int SW = gsa_pkg::SLOT_W;
	localparam int GW = gsa_pkg::GEN_W;
	localparam int IW = gsa_pkg::ID_W;

	gsa_pkg::state_t state_q, state_d;

	logic          init_busy;
	logic [AW-1:0] init_addr;

	logic          s_fire;
	logic          exec_go;

	gsa_pkg::op_t  op_s1;
	logic [SW-1:0] slot_s1;
	logic [IW-1:0] ev_s1;

	logic [LW-1:0] free_head_q, free_head_d;
	logic [LW-1:0] used_q, used_d;

	logic [LW-1:0] link_rd;
	logic [GW-1:0] gen_rd;

	logic          link_we, link_wr_en;
	logic [AW-1:0] link_wa, link_wr_addr;
	logic [LW-1:0] link_wd, link_wr_data;
	logic          gen_we, gen_wr_en;
	logic [AW-1:0] gen_wr_addr;
	logic [GW-1:0] gen_wd, gen_wr_data;

	logic [AW-1:0] gen_rd_addr;

	gsa_pkg::stat_t status_d;
	logic [SW-1:0]  granted_d;
	logic [IW-1:0]  handle_d;

	logic           head_null, slot_ok, ev_ok;
	logic [AW-1:0]  slot_addr;
	logic [GW-1:0]  gen_inc;

	logic                     out_valid_q;
	gsa_pkg::stat_t           out_status_q;
	logic [SW-1:0]            out_granted_q;
	logic [IW-1:0]            out_handle_q;
	logic [gsa_pkg::USED_W-1:0] out_used_q;

	gsa_init #(.SLOTS(SLOTS)) u_init (
		.clk   (clk),
		.arst_n(arst_n),
		.busy  (init_busy),
		.addr  (init_addr)
	);

	gsa_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
		.clk    (clk),
		.wr_en  (link_wr_en),
		.wr_addr(link_wr_addr),
		.wr_data(link_wr_data),
		.rd_en  (s_fire),
		.rd_addr(free_head_q[AW-1:0]),
		.rd_data(link_rd)
	);

	gsa_ram #(.WIDTH(GW), .DEPTH(SLOTS)) u_gen_ram (
		.clk    (clk),
		.wr_en  (gen_wr_en),
		.wr_addr(gen_wr_addr),
		.wr_data(gen_wr_data),
		.rd_en  (s_fire),
		.rd_addr(gen_rd_addr),
		.rd_data(gen_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gsa_pkg::ST_INIT: begin
				if (!init_busy) begin
					state_d = gsa_pkg::ST_IDLE;
				end
			end
			gsa_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = gsa_pkg::ST_EXEC;
				end
			end
			gsa_pkg::ST_EXEC: begin
				if (exec_go) begin
					state_d = gsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gsa_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		s_tready = (state_q == gsa_pkg::ST_IDLE);
		exec_go  = (state_q == gsa_pkg::ST_EXEC) && (!out_valid_q || m_tready);
	end

	assign s_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsa_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		if (gsa_pkg::op_t'(s_tuser) == gsa_pkg::OP_VERIFY) begin
			gen_rd_addr = AW'(s_tdata[gsa_pkg::S_EVENT_LSB +: GW]);
		end else begin
			gen_rd_addr = AW'(s_tdata[gsa_pkg::S_SLOT_LSB +: SW]);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1   <= gsa_pkg::op_t'(s_tuser);
			slot_s1 <= s_tdata[gsa_pkg::S_SLOT_LSB +: SW];
			ev_s1   <= s_tdata[gsa_pkg::S_EVENT_LSB +: IW];
		end
	end

	assign head_null = (free_head_q == LW'(SLOTS));
	assign slot_ok   = (32'(slot_s1) < 32'(SLOTS));
	assign ev_ok     = (ev_s1[GW-1:0] < 32'(SLOTS));
	assign slot_addr = AW'(slot_s1);
	assign gen_inc   = gen_rd + GW'(1);

	always_comb begin
		status_d    = gsa_pkg::STAT_OK;
		granted_d   = '0;
		handle_d    = '0;
		free_head_d = free_head_q;
		used_d      = used_q;
		link_we     = 1'b0;
		link_wa     = slot_addr;
		link_wd     = free_head_q;
		gen_we      = 1'b0;
		gen_wd      = gen_inc;
		case (op_s1)
			gsa_pkg::OP_ALLOC: begin
				if (head_null) begin
					status_d = gsa_pkg::STAT_NOFREE;
				end else begin
					granted_d   = SW'(free_head_q);
					free_head_d = link_rd;
					link_we     = 1'b1;
					link_wa     = free_head_q[AW-1:0];
					link_wd     = LW'(SLOTS);
					if (used_q < LW'(SLOTS)) begin
						used_d = used_q + LW'(1);
					end
				end
			end
			gsa_pkg::OP_FREE: begin
				if (!slot_ok) begin
					status_d = gsa_pkg::STAT_BAD;
				end else begin
					link_we     = 1'b1;
					free_head_d = LW'(slot_s1);
					gen_we      = 1'b1;
					if (used_q != '0) begin
						used_d = used_q - LW'(1);
					end
				end
			end
			gsa_pkg::OP_REARM: begin
				if (!slot_ok) begin
					status_d = gsa_pkg::STAT_BAD;
				end else begin
					gen_we   = 1'b1;
					handle_d = {gen_inc, {(IW - GW - SW){1'b0}}, slot_s1};
				end
			end
			gsa_pkg::OP_READ: begin
				if (!slot_ok) begin
					status_d = gsa_pkg::STAT_BAD;
				end else begin
					handle_d = {gen_rd, {(IW - GW - SW){1'b0}}, slot_s1};
				end
			end
			gsa_pkg::OP_VERIFY: begin
				if (!ev_ok || (gen_rd != ev_s1[IW-1:GW])) begin
					status_d = gsa_pkg::STAT_BAD;
				end
			end
			default: begin
				status_d = gsa_pkg::STAT_OK;
			end
		endcase
	end

	always_comb begin
		if (init_busy) begin
			link_wr_en   = 1'b1;
			link_wr_addr = init_addr;
			link_wr_data = LW'(init_addr) + LW'(1);
			gen_wr_en    = 1'b1;
			gen_wr_addr  = init_addr;
			gen_wr_data  = '0;
		end else begin
			link_wr_en   = exec_go && link_we;
			link_wr_addr = link_wa;
			link_wr_data = link_wd;
			gen_wr_en    = exec_go && gen_we;
			gen_wr_addr  = slot_addr;
			gen_wr_data  = gen_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				free_head_q <= free_head_d;
				used_q      <= used_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_status_q  <= status_d;
			out_granted_q <= granted_d;
			out_handle_q  <= handle_d;
			out_used_q    <= gsa_pkg::USED_W'(used_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(gsa_pkg::M_TDATA_W - gsa_pkg::M_PAYLOAD_W){1'b0}},
		out_used_q, out_handle_q, out_granted_q};

endmodule

@@ rtl/gsa_checker.sv @@
`include "generational_slot_allocator_macros.svh"

module gsa_checker #(
	parameter int SLOTS = 1024
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [gsa_pkg::S_TDATA_W-1:0]   s_tdata,
	input logic [gsa_pkg::OP_W-1:0]        s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [gsa_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic [gsa_pkg::STAT_W-1:0]      m_tuser
);

	logic [gsa_pkg::SLOT_W-1:0] grant_w;
	logic [gsa_pkg::ID_W-1:0]   handle_w;
	logic [gsa_pkg::USED_W-1:0] used_w;
	logic                       in_beat;

	assign grant_w  = m_tdata[gsa_pkg::M_GRANT_LSB +: gsa_pkg::SLOT_W];
	assign handle_w = m_tdata[gsa_pkg::M_HANDLE_LSB +: gsa_pkg::ID_W];
	assign used_w   = m_tdata[gsa_pkg::M_USED_LSB +: gsa_pkg::USED_W];
	assign in_beat  = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

	`GSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Result beat changed while stalled.")
	`GSA_ASSERT_NEXT(a_one_in_flight, in_beat, !s_tready, "Input accepted while an operation was in flight.")
	`GSA_ASSERT_SAME(a_fail_clean, m_tvalid && (m_tuser != gsa_pkg::STAT_OK), (grant_w == '0) && (handle_w == '0), "Failed operation returned a slot or handle.")
	`GSA_ASSERT_SAME(a_used_bound, m_tvalid, (SLOTS > 2047) || (32'(used_w) <= 32'(SLOTS)), "Slot usage count exceeds the table size.")

endmodule

bind generational_slot_allocator gsa_checker #(.SLOTS(SLOTS)) u_gsa_checker (.*);
